// File: rtl/deadline_timer_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Deadline timer queue assertion macros
// Assertion helpers shared by the timer queue modules.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTQ_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTQ_ASSERT(label, clk, rst, prop, msg)
`define DTQ_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Shared types and constants of the timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;
   localparam int unsigned NumTimersDefault = 16;
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;
   localparam logic [1:0] KIND_ID    = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_FULL  = 2'd2;

   // Command from the controller to every cell.
   typedef struct packed {
      logic        add;       // arm this cell if it is the chosen free cell
      logic        cancel;
      logic        fire;      // retire or re-arm the cell that carries the pick
      logic [31:0] value;     // deadline for add, identifier for cancel
      logic [31:0] period;
      logic        repeat_en;
      logic [31:0] ident;
      logic [31:0] order;
   } cell_cmd_type;

   // Candidate that travels down the chain during a scan.
   typedef struct packed {
      logic        found;
      logic [31:0] deadline;
      logic [31:0] order;
      logic [31:0] ident;
   } cand_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction
endpackage

// File: rtl/dtq_cell.sv
// ----------------------------------------------------------------------------
// Timer cell
// Holds one timer and compares it against the candidate passed along the chain.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_core_defines.svh"
module dtq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dtq_pkg::cell_cmd_type cmd,
   input  logic                  add_sel,
   input  logic [31:0]           now_ticks,
   input  logic                  pend,       // still eligible in this update
   input  logic                  sel,        // this cell is the last picked one
   input  dtq_pkg::cand_type     cand_in,
   output dtq_pkg::cand_type     cand_out,
   output logic                  valid,
   output logic                  due,
   output logic [31:0]           order,
   output logic                  rearm
);
   import dtq_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] deadline_ff, period_ff, ident_ff, order_ff;
   logic        repeat_ff;
   logic        better;

   assign valid = valid_ff;
   assign due   = valid_ff && pend && (deadline_ff <= now_ticks);
   assign order = order_ff;
   assign rearm = repeat_ff;

   always_comb begin
      better = !cand_in.found || (deadline_ff < cand_in.deadline) ||
               ((deadline_ff == cand_in.deadline) && (order_ff < cand_in.order));
   end

   // Each cell registers the best candidate so far and hands it on.
   always_ff @(posedge clock) begin
      if (due && better) begin
         cand_out <= '{found: 1'b1, deadline: deadline_ff, order: order_ff,
                       ident: ident_ff};
      end else begin
         cand_out <= cand_in;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.add && add_sel) valid_in = 1'b1;
      if (cmd.cancel && valid_ff && ident_ff == cmd.value) valid_in = 1'b0;
      if (cmd.fire && sel && !repeat_ff) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && add_sel) begin
         deadline_ff <= cmd.value;
         period_ff   <= cmd.period;
         repeat_ff   <= cmd.repeat_en;
         ident_ff    <= cmd.ident;
         order_ff    <= cmd.order;
      end else if (cmd.fire && sel && repeat_ff) begin
         deadline_ff <= sat_add(deadline_ff, period_ff);
         order_ff    <= cmd.order;
      end
   end

   `DTQ_ASSERT(a_add_free, clock, reset, (cmd.add && add_sel) |-> !valid_ff, "add to busy cell")
   `DTQ_ASSERT(a_fire_valid, clock, reset, (cmd.fire && sel) |-> valid_ff, "fire idle cell")
   `DTQ_ASSERT(a_arm, clock, reset, (cmd.add && add_sel) |=> valid_ff, "cell not armed")
endmodule

// File: rtl/deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// Deadline timer queue core
// A chain of timer cells with a controller that adds, cancels and fires.
// ----------------------------------------------------------------------------
// Usage: raise start with req_* for one cycle while busy is low. cmd 0 adds
// a timer and answers one result (kind 0 with the new identifier, or kind 2
// when all cells are armed) in the cycle right after the request is taken.
// cmd 1 cancels and answers nothing; cmd 3 is ignored. cmd 2 sets the
// current time and fires the timers due at that moment in deadline order,
// arming order breaking ties.
// Each fired timer costs one scan of the cell chain plus one update step in
// the fire state, so the time an update keeps busy high grows with the chain
// length and with the number of due timers; an update with no due timer still
// takes one scan.
// Results appear on rsp_* for one cycle with rsp_valid; the last one of a
// request has rsp_last set. The receiver cannot stall, so none is held.
// Reset clears every cell's valid bit and the time and counters; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_core_defines.svh"
module deadline_timer_queue_core #(
   parameter int unsigned NUM_TIMERS = dtq_pkg::NumTimersDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_delay,
   input  logic        req_periodic,
   input  logic [31:0] req_cancel_id,
   input  logic [31:0] req_now_ticks,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_timer_id,
   output logic        rsp_last
);
   import dtq_pkg::*;

   localparam int unsigned CntW = $clog2(NUM_TIMERS + 3);
   localparam logic [CntW-1:0] ScanLast = CntW'(NUM_TIMERS);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIRE} state_type;

   state_type        state_ff;
   cell_cmd_type     cmd;
   cand_type         chain [NUM_TIMERS+1];
   logic [NUM_TIMERS-1:0] valid_v, due_v, sel_ff, free_oh, sel_v;
   logic [NUM_TIMERS-1:0] pend_ff, rearm_v, win_v;
   logic [31:0]      order_v [NUM_TIMERS];
   logic [31:0]      time_ff, ident_ff, order_ff, now_ff;
   logic [CntW-1:0]  cnt_ff;
   logic             add_go;
   cand_type         win;

   assign chain[0] = '0;

   // First free cell, lowest index.
   always_comb begin
      free_oh = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!valid_v[i]) free_oh = '0;
         if (!valid_v[i]) free_oh[i] = 1'b1;
      end
   end

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      assign sel_v[g] = sel_ff[g];
      dtq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .add_sel   (free_oh[g]),
         .now_ticks (now_ff),
         .pend      (pend_ff[g]),
         .sel       (sel_v[g]),
         .cand_in   (chain[g]),
         .cand_out  (chain[g+1]),
         .valid     (valid_v[g]),
         .due       (due_v[g]),
         .order     (order_v[g]),
         .rearm     (rearm_v[g])
      );
   end

   // Winner is identified by its unique arming order among valid cells.
   assign win = chain[NUM_TIMERS];
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         win_v[i] = due_v[i] && (order_v[i] == win.order);
      end
   end

   assign add_go = start && !busy && (req_cmd == CMD_ADD) && (|(~valid_v));
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.add       = add_go;
      cmd.cancel    = start && !busy && (req_cmd == CMD_CANCEL);
      cmd.value     = (req_cmd == CMD_ADD) ? sat_add(time_ff, req_delay) : req_cancel_id;
      cmd.period    = req_delay;
      cmd.repeat_en = req_periodic;
      cmd.ident     = ident_ff + 32'd1;
      cmd.order     = order_ff;
      cmd.fire      = (state_ff == S_FIRE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         time_ff   <= '0;
         ident_ff  <= '0;
         order_ff  <= '0;
         now_ff    <= '0;
         cnt_ff    <= '0;
         sel_ff    <= '0;
         pend_ff   <= '0;
         rsp_valid <= 1'b0;
         rsp_kind  <= KIND_ID;
         rsp_timer_id <= '0;
         rsp_last  <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  case (req_cmd)
                     CMD_ADD: begin
                        rsp_valid <= 1'b1;
                        rsp_last  <= 1'b1;
                        if (add_go) begin
                           rsp_kind     <= KIND_ID;
                           rsp_timer_id <= ident_ff + 32'd1;
                           ident_ff     <= ident_ff + 32'd1;
                           order_ff     <= order_ff + 32'd1;
                        end else begin
                           rsp_kind     <= KIND_FULL;
                           rsp_timer_id <= '0;
                        end
                     end
                     CMD_UPDATE: begin
                        time_ff  <= req_now_ticks;
                        now_ff   <= req_now_ticks;
                        cnt_ff   <= '0;
                        // Every cell may fire once in this update.
                        pend_ff  <= '1;
                        state_ff <= S_SCAN;
                     end
                     default: ;
                  endcase
               end
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ScanLast) begin
                  if (win.found) begin
                     sel_ff       <= win_v;
                     rsp_valid    <= 1'b1;
                     rsp_kind     <= KIND_FIRED;
                     rsp_timer_id <= win.ident;
                     rsp_last     <= ($countones(due_v) == 1);
                     state_ff     <= S_FIRE;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_FIRE: begin
               // Only a re-armed timer takes a new arming number.
               if (|(sel_ff & rearm_v)) order_ff <= order_ff + 32'd1;
               pend_ff  <= pend_ff & ~sel_ff;
               sel_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= rsp_last ? S_IDLE : S_SCAN;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `DTQ_ASSERT(a_sel_onehot, clock, reset, (state_ff == S_FIRE) |-> $onehot(sel_ff), "pick")
   `DTQ_ASSERT(a_rsp_busy, clock, reset, (rsp_valid && rsp_kind == KIND_FIRED) |-> busy, "idle")
   `DTQ_ASSERT(a_scan_bound, clock, reset, (state_ff == S_SCAN) |-> (cnt_ff <= ScanLast), "scan")
endmodule

// File: verif/deadline_timer_queue_core_tb.sv
// ----------------------------------------------------------------------------
// Deadline timer queue core testbench
// A queue of pending requests feeds a clocked driver. A behavioral timer table
// in the testbench predicts the results, and a monitor compares each result
// with the oldest prediction. Directed requests come first, then random ones.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core_tb;
   import dtq_pkg::*;

   localparam int NT = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] delay;
      logic        periodic;
      logic [31:0] cancel_id;
      logic [31:0] now_ticks;
   } timer_req_t;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] timer_id;
      logic        last;
   } timer_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = '0;
   logic [31:0] req_delay = '0;
   logic        req_periodic = 1'b0;
   logic [31:0] req_cancel_id = '0;
   logic [31:0] req_now_ticks = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_timer_id;
   logic        rsp_last;

   deadline_timer_queue_core #(.NUM_TIMERS(NT)) uut (.*);

   // Behavioral timer table.
   logic        tbl_valid [NT];
   logic [31:0] tbl_deadline [NT];
   logic [31:0] tbl_period [NT];
   logic        tbl_repeat [NT];
   logic [31:0] tbl_ident [NT];
   logic [31:0] tbl_order [NT];
   logic [31:0] clock_now = '0;
   logic [31:0] last_ident = '0;
   logic [31:0] next_order = '0;

   timer_req_t pending_reqs[$];
   timer_rsp_t expected_rsps[$];
   int mismatches = 0;
   int cycles = 0;
   int gap = 0;
   bit hold_for_drain = 0;
   bit stimulus_done = 0;

   function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void expect_rsp(logic [1:0] k, logic [31:0] id, logic l);
      timer_rsp_t x;
      x.kind = k;
      x.timer_id = id;
      x.last = l;
      expected_rsps = {expected_rsps, x};
   endfunction

   function automatic void queue_req(timer_req_t r);
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic void predict_timers(timer_req_t r);
      int slot;
      int best;
      logic [NT-1:0] due;
      slot = -1;
      due = '0;
      if (r.cmd == CMD_ADD) begin
         for (int i = 0; i < NT; i++)
            if (!tbl_valid[i] && slot < 0) slot = i;
         if (slot < 0) begin
            expect_rsp(KIND_FULL, 32'd0, 1'b1);
         end else begin
            last_ident = last_ident + 32'd1;
            tbl_valid[slot] = 1'b1;
            tbl_deadline[slot] = clamp_add(clock_now, r.delay);
            tbl_period[slot] = r.delay;
            tbl_repeat[slot] = r.periodic;
            tbl_ident[slot] = last_ident;
            tbl_order[slot] = next_order;
            next_order = next_order + 32'd1;
            expect_rsp(KIND_ID, last_ident, 1'b1);
         end
      end else if (r.cmd == CMD_CANCEL) begin
         for (int i = 0; i < NT; i++)
            if (tbl_valid[i] && tbl_ident[i] == r.cancel_id) tbl_valid[i] = 1'b0;
      end else if (r.cmd == CMD_UPDATE) begin
         clock_now = r.now_ticks;
         for (int i = 0; i < NT; i++)
            due[i] = tbl_valid[i] && tbl_deadline[i] <= r.now_ticks;
         while (due != '0) begin
            best = -1;
            for (int i = 0; i < NT; i++)
               if (due[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best] ||
                   (tbl_deadline[i] == tbl_deadline[best] &&
                    tbl_order[i] < tbl_order[best])))
                  best = i;
            due[best] = 1'b0;
            expect_rsp(KIND_FIRED, tbl_ident[best], due == '0);
            if (tbl_repeat[best]) begin
               tbl_deadline[best] = clamp_add(tbl_deadline[best], tbl_period[best]);
               tbl_order[best] = next_order;
               next_order = next_order + 32'd1;
            end else begin
               tbl_valid[best] = 1'b0;
            end
         end
      end
   endfunction

   function automatic timer_req_t make_req(logic [1:0] c, logic [31:0] d, logic p,
                                           logic [31:0] id, logic [31:0] t);
      timer_req_t r;
      r.cmd = c;
      r.delay = d;
      r.periodic = p;
      r.cancel_id = id;
      r.now_ticks = t;
      return r;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
      return $urandom_range(0, 4);
   endfunction

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < NT; i++) tbl_valid[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Directed requests, then random ones with small time steps so timers fire.
   initial begin
      logic [31:0] t;
      logic [1:0] c;
      queue_req(make_req(CMD_ADD, 32'd0, 1'b0, 32'd0, 32'd0));
      queue_req(make_req(CMD_ADD, 32'd5, 1'b1, 32'd0, 32'd0));
      queue_req(make_req(CMD_ADD, 32'd5, 1'b0, 32'd0, 32'd0));
      queue_req(make_req(CMD_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'd0));
      queue_req(make_req(CMD_ADD, 32'd0, 1'b1, 32'd0, 32'd0));
      queue_req(make_req(CMD_UPDATE, 32'd0, 1'b0, 32'd0, 32'd0));
      queue_req(make_req(CMD_UPDATE, 32'd0, 1'b0, 32'd0, 32'd100));
      queue_req(make_req(CMD_CANCEL, 32'd0, 1'b0, 32'd5, 32'd0));
      queue_req(make_req(CMD_CANCEL, 32'd0, 1'b0, 32'hDEAD_BEEF, 32'd0));
      queue_req(make_req(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      for (int i = 0; i < 17; i++)
         queue_req(make_req(CMD_ADD, 32'd50 + i[31:0], i[0], 32'd0, 32'd0));
      queue_req(make_req(CMD_UPDATE, 32'd0, 1'b0, 32'd0, 32'hFFFF_FFFF));
      queue_req(make_req(CMD_UPDATE, 32'd0, 1'b0, 32'd0, 32'd10));
      t = 32'd10;
      for (int i = 0; i < 190; i++) begin
         c = $urandom_range(0, 9) < 5 ? CMD_ADD :
             $urandom_range(0, 9) < 5 ? CMD_UPDATE :
             $urandom_range(0, 9) == 0 ? CMD_UNUSED : CMD_CANCEL;
         if (c == CMD_UPDATE)
            t = ($urandom_range(0, 19) == 0) ? $urandom() : t + $urandom_range(0, 60);
         queue_req(make_req(c,
            ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 80),
            1'($urandom_range(0, 1)),
            ($urandom_range(0, 3) == 0) ? $urandom() : last_ident + $urandom_range(0, 40),
            t));
      end
      stimulus_done = 1;
   end

   // Driver: one request per accept, random gaps, one drain pause midway.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         predict_timers({req_cmd, req_delay, req_periodic, req_cancel_id, req_now_ticks});
         gap <= pick_gap();
         if (pending_reqs.size() == 110) hold_for_drain <= 1;
         start <= 1'b0;
      end else if (!start) begin
         if (hold_for_drain) begin
            if (expected_rsps.size() == 0 && !busy) hold_for_drain <= 0;
         end else if (gap > 0) begin
            gap <= gap - 1;
         end else if (pending_reqs.size() > 0) begin
            timer_req_t r;
            r = pending_reqs.pop_front();
            {req_cmd, req_delay, req_periodic, req_cancel_id, req_now_ticks} <= r;
            start <= 1'b1;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         timer_rsp_t e;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result kind=%0d id=%0h last=%0b",
                        rsp_kind, rsp_timer_id, rsp_last);
         end else begin
            e = expected_rsps.pop_front();
            if (e.kind !== rsp_kind || e.timer_id !== rsp_timer_id || e.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected kind=%0d id=%0h last=%0b, got %0d %0h %0b",
                           e.kind, e.timer_id, e.last, rsp_kind, rsp_timer_id, rsp_last);
            end
         end
      end
   end

   initial begin
      while (!(stimulus_done && pending_reqs.size() == 0 && !start && !busy &&
               expected_rsps.size() == 0) && cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         repeat (400) @(posedge clock);
         if (mismatches == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
         else
            $display("CHECK FAILED");
         $finish;
      end
   end
endmodule
